// ===== rtl/core/gbcd_pkg.sv =====
// Shared types, constants and tables of the gyro bias calibration block.
`timescale 1ns / 1ps
package gbcd_pkg;

   localparam int AXES    = 3;
   localparam int RAW_W   = 16;
   localparam int SUM_W   = 25;
   localparam int SQ_W    = 39;
   localparam int MAG_W   = 24;
   localparam int DIVD_W  = 47;
   localparam int DIVS_W  = 17;
   localparam int RATE_W  = 20;
   localparam int FACT_W  = 20;
   localparam int THR_W   = 24;
   localparam int PROD_W  = 36;
   localparam int CSR_W   = 8;
   localparam int SQRT_STEPS = 16;
   localparam int DCNT_W  = $clog2(DIVD_W);
   localparam int SCNT_W  = $clog2(SQRT_STEPS);

   typedef logic [1:0] csr_addr_type;
   localparam csr_addr_type CSR_GYRO_SCALE    = 2'd0;
   localparam csr_addr_type CSR_THRESH_MULT   = 2'd1;
   localparam csr_addr_type CSR_CALIB_SAMPLES = 2'd2;

   localparam logic [CSR_W-1:0] CALIB_SAMPLES_RESET = 8'd50;

   typedef struct packed {
      logic                    command;
      logic signed [RAW_W-1:0] gyro_x;
      logic signed [RAW_W-1:0] gyro_y;
      logic signed [RAW_W-1:0] gyro_z;
   } req_type;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_y;
      logic signed [RATE_W-1:0] rate_z;
      logic                     is_calibrated;
      logic                     calib_done;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MEAS1,
      ST_MEAS2,
      ST_MEAS3,
      ST_CAL_ACC,
      ST_FIN_ABS,
      ST_FIN_MUL,
      ST_DIV_Q,
      ST_FIN_SUB,
      ST_DIV_V,
      ST_SQRT_LD,
      ST_SQRT,
      ST_FIN_STORE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic meas1;
      logic meas2;
      logic meas3;
      logic cal_acc;
      logic fin_abs;
      logic fin_mul;
      logic div_step;
      logic fin_sub;
      logic sqrt_ld;
      logic sqrt_step;
      logic fin_store;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic meas_cmd;
      logic cal_hit;
      logic div_last;
      logic sqrt_last;
      logic last_axis;
   } status_type;

   function automatic logic [FACT_W-1:0] scale_factor(input logic [1:0] sel);
      logic [FACT_W-1:0] f;
      case (sel)
         2'd0: f = 20'd128060;
         2'd1: f = 20'd256138;
         2'd2: f = 20'd511487;
         2'd3: f = 20'd1022991;
         default: f = 20'd128060;
      endcase
      return f;
   endfunction

endpackage

// ===== rtl/core/gbcd_ctrl.sv =====
// Sequencer state machine of the gyro bias calibration block.
`timescale 1ns / 1ps
module gbcd_ctrl
   import gbcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH:  state_in = status.meas_cmd ? ST_MEAS1 : ST_CAL_ACC;
         ST_MEAS1:     state_in = ST_MEAS2;
         ST_MEAS2:     state_in = ST_MEAS3;
         ST_MEAS3:     state_in = ST_RESP;
         ST_CAL_ACC:   state_in = status.cal_hit ? ST_FIN_ABS : ST_RESP;
         ST_FIN_ABS:   state_in = ST_FIN_MUL;
         ST_FIN_MUL:   state_in = ST_DIV_Q;
         ST_DIV_Q:     if (status.div_last) state_in = ST_FIN_SUB;
         ST_FIN_SUB:   state_in = ST_DIV_V;
         ST_DIV_V:     if (status.div_last) state_in = ST_SQRT_LD;
         ST_SQRT_LD:   state_in = ST_SQRT;
         ST_SQRT:      if (status.sqrt_last) state_in = ST_FIN_STORE;
         ST_FIN_STORE: state_in = status.last_axis ? ST_RESP : ST_FIN_ABS;
         ST_RESP:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:      cmd.capture   = req_valid;
         ST_MEAS1:     cmd.meas1     = 1'b1;
         ST_MEAS2:     cmd.meas2     = 1'b1;
         ST_MEAS3:     cmd.meas3     = 1'b1;
         ST_CAL_ACC:   cmd.cal_acc   = 1'b1;
         ST_FIN_ABS:   cmd.fin_abs   = 1'b1;
         ST_FIN_MUL:   cmd.fin_mul   = 1'b1;
         ST_DIV_Q:     cmd.div_step  = 1'b1;
         ST_FIN_SUB:   cmd.fin_sub   = 1'b1;
         ST_DIV_V:     cmd.div_step  = 1'b1;
         ST_SQRT_LD:   cmd.sqrt_ld   = 1'b1;
         ST_SQRT:      cmd.sqrt_step = 1'b1;
         ST_FIN_STORE: cmd.fin_store = 1'b1;
         ST_RESP:      cmd.rsp_load  = out_free;
         default:      cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while pending");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted request not dispatched");

   a_quot_to_sub: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_Q && status.div_last) |=> cmd.fin_sub)
      else $error("mean divide did not hand over to variance step");

endmodule

// ===== rtl/core/gbcd_dp.sv =====
// Datapath: accumulators, divider, square root, deadband and scaling.
`timescale 1ns / 1ps
module gbcd_dp
   import gbcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  csr_addr_type       csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  cmd_type            cmd,
   output status_type         status
);

   req_type                   req_ff;
   rsp_type                   rsp_ff;
   logic [1:0]                scale_ff;
   logic [CSR_W-1:0]          mult_ff;
   logic [CSR_W-1:0]          ncal_ff;

   logic signed [SUM_W-1:0]   sum_ff   [AXES];
   logic [SQ_W-1:0]           sumsq_ff [AXES];
   logic signed [RAW_W-1:0]   ofs_ff   [AXES];
   logic [RAW_W-1:0]          dev_ff   [AXES];
   logic [CSR_W-1:0]          cnt_ff;
   logic [CSR_W:0]            n_ff;
   logic                      flag_ff;
   logic                      done_ff;
   logic [1:0]                ax_ff;

   logic [RAW_W-1:0]          mag_ff  [AXES];
   logic                      neg_ff  [AXES];
   logic [THR_W-1:0]          thr_ff  [AXES];
   logic [PROD_W-1:0]         prod_ff [AXES];
   logic signed [RATE_W-1:0]  rate_ff [AXES];

   logic [MAG_W-1:0]          smag_ff;
   logic                      sneg_ff;
   logic [DIVS_W-1:0]         nn_ff;
   logic [DIVD_W-1:0]         pa_ff, pb_ff;

   logic [DIVD_W-1:0]         quo_ff;
   logic [DIVS_W:0]           rem_ff;
   logic [DIVS_W-1:0]         dsr_ff;
   logic [DCNT_W-1:0]         dcnt_ff;

   logic [31:0]               sv_ff, sres_ff, sbit_ff;
   logic [SCNT_W-1:0]         scnt_ff;

   logic signed [RAW_W-1:0]   raw   [AXES];
   logic signed [RAW_W:0]     c17   [AXES];
   logic signed [RAW_W-1:0]   c16   [AXES];
   logic [RAW_W-1:0]          magc  [AXES];
   logic [RAW_W-1:0]          mz    [AXES];
   logic [RATE_W-1:0]         rnd   [AXES];
   logic signed [2*RAW_W-1:0] sq    [AXES];
   logic [CSR_W-1:0]          cnt_new, target;
   logic [FACT_W-1:0]         fact;
   logic signed [SUM_W-1:0]   s_sel;
   logic [DIVS_W:0]           rem_sh;
   logic [31:0]               strial;
   logic [RAW_W-1:0]          qlow;

   assign raw[0] = req_ff.gyro_x;
   assign raw[1] = req_ff.gyro_y;
   assign raw[2] = req_ff.gyro_z;
   assign fact   = scale_factor(scale_ff);

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         c17[a] = {raw[a][RAW_W-1], raw[a]}
                - (flag_ff ? {ofs_ff[a][RAW_W-1], ofs_ff[a]} : '0);
         if (c17[a][RAW_W] != c17[a][RAW_W-1])
            c16[a] = c17[a][RAW_W] ? 16'sh8000 : 16'sh7FFF;
         else
            c16[a] = c17[a][RAW_W-1:0];
         magc[a] = c16[a][RAW_W-1] ? RAW_W'(-c16[a]) : RAW_W'(c16[a]);
         mz[a]   = (THR_W'(mag_ff[a]) < thr_ff[a]) ? '0 : mag_ff[a];
         rnd[a]  = RATE_W'((prod_ff[a] + PROD_W'(32768)) >> 16);
         sq[a]   = raw[a] * raw[a];
      end
   end

   assign cnt_new = cnt_ff + 8'd1;
   assign target  = (ncal_ff == '0) ? 8'd1 : ncal_ff;
   assign s_sel   = sum_ff[ax_ff];
   assign rem_sh  = {rem_ff[DIVS_W-1:0], quo_ff[DIVD_W-1]};
   assign strial  = sres_ff + sbit_ff;
   assign qlow    = quo_ff[RAW_W-1:0];

   assign status.meas_cmd  = req_ff.command;
   assign status.cal_hit   = (cnt_new >= target) || (cnt_new == '0);
   assign status.div_last  = (dcnt_ff == DCNT_W'(DIVD_W-1));
   assign status.sqrt_last = (scnt_ff == SCNT_W'(SQRT_STEPS-1));
   assign status.last_axis = (ax_ff == 2'(AXES-1));

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
         mult_ff  <= '0;
         ncal_ff  <= CALIB_SAMPLES_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_GYRO_SCALE:    scale_ff <= csr_wdata[1:0];
            CSR_THRESH_MULT:   mult_ff  <= csr_wdata;
            CSR_CALIB_SAMPLES: ncal_ff  <= csr_wdata;
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            sum_ff[a]   <= '0;
            sumsq_ff[a] <= '0;
            ofs_ff[a]   <= '0;
            dev_ff[a]   <= '0;
         end
         cnt_ff  <= '0;
         flag_ff <= 1'b0;
         ax_ff   <= '0;
      end else begin
         if (cmd.cal_acc) begin
            for (int a = 0; a < AXES; a++) begin
               sum_ff[a]   <= sum_ff[a] + SUM_W'(raw[a]);
               sumsq_ff[a] <= sumsq_ff[a] + SQ_W'($unsigned(sq[a]));
            end
            cnt_ff <= cnt_new;
         end
         if (cmd.fin_sub) begin
            ofs_ff[ax_ff] <= sneg_ff ? -$signed(qlow) : $signed(qlow);
         end
         if (cmd.fin_store) begin
            dev_ff[ax_ff]   <= sres_ff[RAW_W-1:0];
            sum_ff[ax_ff]   <= '0;
            sumsq_ff[ax_ff] <= '0;
            if (ax_ff == 2'(AXES-1)) begin
               ax_ff   <= '0;
               cnt_ff  <= '0;
               flag_ff <= 1'b1;
            end else begin
               ax_ff <= ax_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.meas1) begin
         for (int a = 0; a < AXES; a++) begin
            mag_ff[a] <= magc[a];
            neg_ff[a] <= c16[a][RAW_W-1];
            thr_ff[a] <= {8'b0, dev_ff[a]} * {16'b0, mult_ff};
         end
      end
      if (cmd.meas2) begin
         for (int a = 0; a < AXES; a++)
            prod_ff[a] <= {20'b0, mz[a]} * {16'b0, fact};
      end
      if (cmd.meas3) begin
         for (int a = 0; a < AXES; a++)
            rate_ff[a] <= neg_ff[a] ? -$signed(rnd[a]) : $signed(rnd[a]);
         done_ff <= 1'b0;
      end
      if (cmd.cal_acc) begin
         for (int a = 0; a < AXES; a++) rate_ff[a] <= '0;
         done_ff <= 1'b0;
         n_ff    <= (cnt_new == '0) ? 9'd256 : {1'b0, cnt_new};
      end
      if (cmd.fin_store && (ax_ff == 2'(AXES-1))) done_ff <= 1'b1;
      if (cmd.fin_abs) begin
         smag_ff <= s_sel[SUM_W-1] ? MAG_W'(-s_sel) : MAG_W'(s_sel);
         sneg_ff <= s_sel[SUM_W-1];
         nn_ff   <= DIVS_W'({9'b0, n_ff} * {9'b0, n_ff});
      end
      if (cmd.fin_mul) begin
         pa_ff   <= {38'b0, n_ff} * {8'b0, sumsq_ff[ax_ff]};
         pb_ff   <= {23'b0, smag_ff} * {23'b0, smag_ff};
         quo_ff  <= {23'b0, smag_ff};
         dsr_ff  <= {8'b0, n_ff};
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.fin_sub) begin
         quo_ff  <= pa_ff - pb_ff;
         dsr_ff  <= nn_ff;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_ff <= rem_sh - {1'b0, dsr_ff};
            quo_ff <= {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[DIVD_W-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
      end
      if (cmd.sqrt_ld) begin
         sv_ff   <= quo_ff[31:0];
         sres_ff <= '0;
         sbit_ff <= 32'h4000_0000;
         scnt_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         if (sv_ff >= strial) begin
            sv_ff   <= sv_ff - strial;
            sres_ff <= (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
         sbit_ff <= sbit_ff >> 2;
         scnt_ff <= scnt_ff + SCNT_W'(1);
      end
      if (cmd.rsp_load) begin
         rsp_ff.rate_x        <= rate_ff[0];
         rsp_ff.rate_y        <= rate_ff[1];
         rsp_ff.rate_z        <= rate_ff[2];
         rsp_ff.is_calibrated <= flag_ff;
         rsp_ff.calib_done    <= done_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/core/gyro_bias_calibrate_deadband.sv =====
// Top level of the three-axis gyro bias calibration and deadband block.
// One request is processed at a time. A measurement request passes through the
// dispatch state and the states MEAS1, MEAS2 and MEAS3 before its response is
// valid; a calibration request that does not finish the run passes through the
// dispatch and accumulate states only. In both cases the next request can be
// accepted in the cycle after the response is loaded. The request that completes
// calibration runs the shared divider for the mean (47 steps) and the variance
// (47 steps) and the 16-step square root for each axis in turn, and req_ready
// stays low until its response is loaded. A new request is taken once the
// previous response has been loaded into the output register, even while that
// response still waits for rsp_ready.
`timescale 1ns / 1ps
module gyro_bias_calibrate_deadband
   import gbcd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  csr_addr_type     csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   gbcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gbcd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the gyro bias calibration and deadband block.
`timescale 1ns / 1ps
module testbench;
   import gbcd_pkg::*;

   localparam logic CMD_CALIB = 1'b0;
   localparam logic CMD_MEAS  = 1'b1;
   localparam int CYCLE_LIMIT = 3000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   csr_addr_type     csr_addr = CSR_GYRO_SCALE;
   logic [CSR_W-1:0] csr_wdata = '0;

   gyro_bias_calibrate_deadband dut (.*);

   always #10 clock = ~clock;

   req_type pending_requests[$];
   rsp_type expected_rates[$];
   logic    req_taken = 1'b0;
   int      idle_pct = 35;
   int      mismatches = 0;
   int      cycles = 0;

   // block state mirror
   logic [1:0]        scale_sel;
   logic [7:0]        thresh_mult;
   logic [7:0]        calib_target;
   longint            sum_acc[3];
   longint unsigned   sumsq_acc[3];
   logic [7:0]        taken_cnt;
   logic signed [15:0] bias[3];
   logic [15:0]       noise_dev[3];
   logic              calibrated;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic [19:0] scale_rate(input int c);
      longint unsigned mag, r, fact;
      case (scale_sel)
         2'd0: fact = 128060;
         2'd1: fact = 256138;
         2'd2: fact = 511487;
         default: fact = 1022991;
      endcase
      mag = (c < 0) ? longint'(-c) : longint'(c);
      r = (mag * fact + 32768) >> 16;
      if (c < 0) r = -r;
      return r[19:0];
   endfunction

   function automatic rsp_type predict_rates(input req_type rq);
      rsp_type r;
      int raw[3];
      int c, a;
      longint unsigned n, smag, num, thr, mag, tgt;
      r = '0;
      raw[0] = int'(rq.gyro_x);
      raw[1] = int'(rq.gyro_y);
      raw[2] = int'(rq.gyro_z);
      if (rq.command == CMD_CALIB) begin
         tgt = (calib_target == 0) ? 1 : calib_target;
         for (a = 0; a < 3; a++) begin
            sum_acc[a] += raw[a];
            sumsq_acc[a] += longint'(raw[a]) * longint'(raw[a]);
         end
         taken_cnt = taken_cnt + 8'd1;
         if (taken_cnt >= tgt || taken_cnt == 0) begin
            n = (taken_cnt == 0) ? 256 : taken_cnt;
            for (a = 0; a < 3; a++) begin
               smag = (sum_acc[a] < 0) ? -sum_acc[a] : sum_acc[a];
               num = n * sumsq_acc[a] - smag * smag;
               bias[a] = 16'((sum_acc[a] < 0) ? -(smag / n) : (smag / n));
               noise_dev[a] = 16'(int_sqrt(num / (n * n)));
               sum_acc[a] = 0;
               sumsq_acc[a] = 0;
            end
            taken_cnt = 0;
            calibrated = 1'b1;
            r.calib_done = 1'b1;
         end
         r.is_calibrated = calibrated;
         return r;
      end
      for (a = 0; a < 3; a++) begin
         c = raw[a];
         if (calibrated) c -= bias[a];
         if (c > 32767) c = 32767;
         if (c < -32768) c = -32768;
         if (thresh_mult != 0) begin
            mag = (c < 0) ? longint'(-c) : longint'(c);
            thr = longint'(noise_dev[a]) * thresh_mult;
            if (mag < thr) c = 0;
         end
         case (a)
            0: r.rate_x = scale_rate(c);
            1: r.rate_y = scale_rate(c);
            default: r.rate_z = scale_rate(c);
         endcase
      end
      r.is_calibrated = calibrated;
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // monitor: check results, then predict newly accepted requests
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = expected_rates.pop_front();
            if (want.rate_x !== rsp_data.rate_x || want.rate_y !== rsp_data.rate_y ||
                want.rate_z !== rsp_data.rate_z ||
                want.is_calibrated !== rsp_data.is_calibrated ||
                want.calib_done !== rsp_data.calib_done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
      if (!reset && req_valid && req_ready) expected_rates.push_back(predict_rates(req_data));
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
         if (req_valid && !req_taken) begin
            req_valid <= 1'b1;
         end else if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_data <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic write_reg(input csr_addr_type idx, input logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_GYRO_SCALE: scale_sel = val[1:0];
         CSR_THRESH_MULT: thresh_mult = val;
         default: calib_target = val;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [1:0] sc, input logic [7:0] mult,
                            input logic [7:0] cnt);
      write_reg(CSR_GYRO_SCALE, {6'b0, sc});
      write_reg(CSR_THRESH_MULT, mult);
      write_reg(CSR_CALIB_SAMPLES, cnt);
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      #1;
      while ((pending_requests.size() > 0 || req_valid || expected_rates.size() > 0)
             && guard < 200000) begin
         @(negedge clock);
         #1;
         guard++;
      end
      repeat (10) @(negedge clock);
   endtask

   task automatic add_sample(input logic cmd, input int x, input int y, input int z);
      req_type rq;
      rq.command = cmd;
      rq.gyro_x = x[15:0];
      rq.gyro_y = y[15:0];
      rq.gyro_z = z[15:0];
      pending_requests.push_back(rq);
   endtask

   function automatic int jitter(input int center, input int spread);
      int v;
      v = center + int'($urandom_range(2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   initial begin
      int items, cnt, k, bx, by, bz, spread, nmeas;
      scale_sel = 0;
      thresh_mult = 0;
      calib_target = CALIB_SAMPLES_RESET;
      for (k = 0; k < 3; k++) begin
         sum_acc[k] = 0;
         sumsq_acc[k] = 0;
         bias[k] = 0;
         noise_dev[k] = 0;
      end
      taken_cnt = 0;
      calibrated = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // uncalibrated extremes at reset settings
      add_sample(CMD_MEAS, 32767, -32768, 0);
      add_sample(CMD_MEAS, -1, 1, -32768);
      add_sample(CMD_MEAS, 21845, -21846, 32767);
      drain();

      // single-sample calibration, full scale, widest deadband
      configure(2'd3, 8'd255, 8'd1);
      add_sample(CMD_CALIB, -32768, 32767, 5);
      add_sample(CMD_MEAS, 32767, -32768, 5);
      add_sample(CMD_MEAS, -32768, 32767, -6);
      drain();

      // zero count acts as one
      configure(2'd1, 8'd0, 8'd0);
      add_sample(CMD_CALIB, 100, -200, 300);
      add_sample(CMD_MEAS, 99, -201, 301);
      drain();

      // count lowered in the middle of a run
      configure(2'd2, 8'd3, 8'd5);
      add_sample(CMD_CALIB, 10, 20, -30);
      add_sample(CMD_CALIB, 14, 24, -26);
      add_sample(CMD_CALIB, 6, 16, -34);
      drain();
      write_reg(CSR_CALIB_SAMPLES, 8'd2);
      add_sample(CMD_CALIB, 12, 18, -32);
      add_sample(CMD_MEAS, 12, 21, -40);
      add_sample(CMD_MEAS, 30, 19, -31);
      drain();

      items = 0;
      for (int ph = 0; items < 650; ph++) begin
         idle_pct = (ph == 2) ? 0 : 35;
         if (ph == 3) cnt = 255;
         else cnt = $urandom_range(2, 12);
         configure(2'($urandom_range(3)), (ph % 4 == 0) ? 8'd0 :
                   (ph % 4 == 1) ? 8'd255 : 8'($urandom_range(1, 6)), 8'(cnt));
         bx = jitter(0, 20000);
         by = jitter(0, 20000);
         bz = jitter(0, 20000);
         spread = ($urandom_range(3) == 0) ? 3000 : $urandom_range(1, 40);
         for (k = 0; k < cnt; k++)
            add_sample(CMD_CALIB, jitter(bx, spread), jitter(by, spread), jitter(bz, spread));
         nmeas = $urandom_range(20, 60);
         for (k = 0; k < nmeas; k++) begin
            if ($urandom_range(9) == 0)
               add_sample(1'($urandom_range(1)), $urandom_range(65535) - 32768,
                          $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
            else
               add_sample(CMD_MEAS, jitter(bx, 4 * spread), jitter(by, 4 * spread),
                          jitter(bz, 4 * spread));
         end
         items += cnt + nmeas;
         drain();
      end

      if (mismatches == 0 && expected_rates.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/gbcd_pkg.sv
rtl/core/gbcd_ctrl.sv
rtl/core/gbcd_dp.sv
rtl/core/gyro_bias_calibrate_deadband.sv
test/testbench.sv
